FILE: rtl/core/otl_pkg.sv
// ----------------------------------------------------------------------------
// otl_pkg
// Shared types, constants and decode functions of the operator token lexer.
// ----------------------------------------------------------------------------
package otl_pkg;

  localparam int PosWidth  = 16;
  localparam int ErrPosW   = 16;
  localparam int QDepth    = 4;
  localparam int QAw       = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSpace = 8'h20;

  // Pending prefix codes
  localparam logic [3:0] PfxNone  = 4'd0;
  localparam logic [3:0] PfxGt    = 4'd1;
  localparam logic [3:0] PfxLt    = 4'd2;
  localparam logic [3:0] PfxBang  = 4'd3;
  localparam logic [3:0] PfxEq    = 4'd4;
  localparam logic [3:0] PfxPlus  = 4'd5;
  localparam logic [3:0] PfxMinus = 4'd6;
  localparam logic [3:0] PfxStar  = 4'd7;
  localparam logic [3:0] PfxSlash = 4'd8;

  // Token codes
  localparam logic [4:0] TokGe      = 5'd0;
  localparam logic [4:0] TokShr     = 5'd1;
  localparam logic [4:0] TokGt      = 5'd2;
  localparam logic [4:0] TokLe      = 5'd3;
  localparam logic [4:0] TokShl     = 5'd4;
  localparam logic [4:0] TokLt      = 5'd5;
  localparam logic [4:0] TokNe      = 5'd6;
  localparam logic [4:0] TokNot     = 5'd7;
  localparam logic [4:0] TokEqEq    = 5'd8;
  localparam logic [4:0] TokAssign  = 5'd9;
  localparam logic [4:0] TokAddEq   = 5'd10;
  localparam logic [4:0] TokInc     = 5'd11;
  localparam logic [4:0] TokAdd     = 5'd12;
  localparam logic [4:0] TokSubEq   = 5'd13;
  localparam logic [4:0] TokDec     = 5'd14;
  localparam logic [4:0] TokSub     = 5'd15;
  localparam logic [4:0] TokMulEq   = 5'd16;
  localparam logic [4:0] TokMul     = 5'd17;
  localparam logic [4:0] TokDivEq   = 5'd18;
  localparam logic [4:0] TokDiv     = 5'd19;
  localparam logic [4:0] TokMod     = 5'd20;
  localparam logic [4:0] TokNone    = 5'd0;

  typedef struct packed {
    logic [4:0]         code;
    logic               err;
    logic [ErrPosW-1:0] pos;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic [4:0] code;
  } ext_t;

  function automatic logic [3:0] prefix_of(input logic [7:0] c);
    logic [3:0] p;
    case (c)
      ChGt:    p = PfxGt;
      ChLt:    p = PfxLt;
      ChBang:  p = PfxBang;
      ChEq:    p = PfxEq;
      ChPlus:  p = PfxPlus;
      ChMinus: p = PfxMinus;
      ChStar:  p = PfxStar;
      ChSlash: p = PfxSlash;
      default: p = PfxNone;
    endcase
    return p;
  endfunction

  function automatic logic pfx_valid(input logic [3:0] p);
    return (p >= PfxGt) && (p <= PfxSlash);
  endfunction

  function automatic logic [4:0] single_code(input logic [3:0] p);
    logic [4:0] t;
    case (p)
      PfxGt:    t = TokGt;
      PfxLt:    t = TokLt;
      PfxBang:  t = TokNot;
      PfxEq:    t = TokAssign;
      PfxPlus:  t = TokAdd;
      PfxMinus: t = TokSub;
      PfxStar:  t = TokMul;
      PfxSlash: t = TokDiv;
      default:  t = TokNone;
    endcase
    return t;
  endfunction

  function automatic ext_t extend(input logic [3:0] p, input logic [7:0] c);
    ext_t e;
    e.hit  = 1'b0;
    e.code = TokNone;
    case (p)
      PfxGt: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokGe;
        end else if (c == ChGt) begin
          e.hit = 1'b1; e.code = TokShr;
        end
      end
      PfxLt: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokLe;
        end else if (c == ChLt) begin
          e.hit = 1'b1; e.code = TokShl;
        end
      end
      PfxBang: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokNe;
        end
      end
      PfxEq: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokEqEq;
        end
      end
      PfxPlus: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokAddEq;
        end else if (c == ChPlus) begin
          e.hit = 1'b1; e.code = TokInc;
        end
      end
      PfxMinus: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokSubEq;
        end else if (c == ChMinus) begin
          e.hit = 1'b1; e.code = TokDec;
        end
      end
      PfxStar: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokMulEq;
        end
      end
      PfxSlash: begin
        if (c == ChEq) begin
          e.hit = 1'b1; e.code = TokDivEq;
        end
      end
      default: e.hit = 1'b0;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/core/otl_front.sv
// ----------------------------------------------------------------------------
// otl_front
// Lexer state machine: classifies each accepted item and builds a queue
// entry holding the one or two results that it causes.
// ----------------------------------------------------------------------------
module otl_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            char_code,
  input  logic                  end_of_text,
  output logic                  push,
  output otl_pkg::entry_t       entry
);

  logic [3:0]                     pending;
  logic [3:0]                     pending_next;
  logic                           err_latched;
  logic                           err_latched_next;
  logic [otl_pkg::PosWidth-1:0]   char_pos;
  logic [otl_pkg::PosWidth-1:0]   char_pos_next;

  otl_pkg::res_t                  res [2];
  logic [1:0]                     n;
  logic                           fresh;
  otl_pkg::ext_t                  ext;
  logic [3:0]                     pfx;
  logic [otl_pkg::ErrPosW-1:0]    err_pos;

  // Saturate the running position into the error position field
  always_comb begin
    if (char_pos > otl_pkg::PosWidth'(otl_pkg::ErrPosW'('1))) begin
      err_pos = '1;
    end else begin
      err_pos = otl_pkg::ErrPosW'(char_pos);
    end
  end

  always_comb begin
    res[0]           = '0;
    res[1]           = '0;
    n                = 2'd0;
    fresh            = 1'b1;
    pending_next     = pending;
    err_latched_next = err_latched;
    char_pos_next    = char_pos;
    ext              = otl_pkg::extend(pending, char_code);
    pfx              = otl_pkg::prefix_of(char_code);

    if (end_of_text) begin
      if (!err_latched && otl_pkg::pfx_valid(pending)) begin
        res[0].code = otl_pkg::single_code(pending);
        n           = 2'd1;
      end
      pending_next     = otl_pkg::PfxNone;
      err_latched_next = 1'b0;
      char_pos_next    = '0;
    end else begin
      if (char_pos != '1) begin
        char_pos_next = char_pos + 1'b1;
      end
      if (!err_latched) begin
        if (otl_pkg::pfx_valid(pending)) begin
          n = 2'd1;
          if (ext.hit) begin
            res[0].code = ext.code;
            fresh       = 1'b0;
          end else begin
            res[0].code = otl_pkg::single_code(pending);
          end
        end
        pending_next = otl_pkg::PfxNone;
        if (fresh && char_code != otl_pkg::ChSpace) begin
          if (pfx != otl_pkg::PfxNone) begin
            pending_next = pfx;
          end else if (char_code == otl_pkg::ChPct) begin
            res[n[0]].code = otl_pkg::TokMod;
            n              = n + 2'd1;
          end else begin
            res[n[0]].err  = 1'b1;
            res[n[0]].pos  = err_pos;
            n              = n + 2'd1;
            err_latched_next = 1'b1;
          end
        end
      end
    end
  end

  assign push      = accept && (n != 2'd0);
  assign entry.two = n[1];
  assign entry.r0  = res[0];
  assign entry.r1  = res[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= otl_pkg::PfxNone;
      err_latched <= 1'b0;
      char_pos    <= '0;
    end else if (accept) begin
      pending     <= pending_next;
      err_latched <= err_latched_next;
      char_pos    <= char_pos_next;
    end
  end

endmodule

FILE: rtl/core/otl_queue.sv
// ----------------------------------------------------------------------------
// otl_queue
// Short entry queue between the lexer front and the result back end.
// ----------------------------------------------------------------------------
module otl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  otl_pkg::entry_t push_entry,
  input  logic            pop,
  output otl_pkg::entry_t pop_entry,
  output logic            full,
  output logic            empty
);

  otl_pkg::entry_t              mem [otl_pkg::QDepth];
  logic [otl_pkg::QAw-1:0]      wr_ptr;
  logic [otl_pkg::QAw-1:0]      rd_ptr;
  logic [otl_pkg::QCntW-1:0]    count;
  logic                         do_push;
  logic                         do_pop;

  assign full      = (count == otl_pkg::QCntW'(otl_pkg::QDepth));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/otl_back.sv
// ----------------------------------------------------------------------------
// otl_back
// Result back end: expands each queue entry into one or two result items
// through the output register.
// ----------------------------------------------------------------------------
module otl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  otl_pkg::entry_t             q_entry,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  token_code,
  output logic                        is_error,
  output logic [otl_pkg::ErrPosW-1:0] error_position,
  output logic                        last
);

  logic          load;
  logic          sub;
  logic          second;
  otl_pkg::res_t sel;

  assign load   = !out_valid || !out_stall;
  assign second = q_entry.two && sub;
  assign sel    = second ? q_entry.r1 : q_entry.r0;
  // Pop once the final result of the entry moves into the output register
  assign q_pop  = load && !q_empty && (!q_entry.two || sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        sub <= q_entry.two && !sub;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      token_code     <= sel.code;
      is_error       <= sel.err;
      error_position <= sel.pos;
      last           <= !(q_entry.two && !sub);
    end
  end

endmodule

FILE: rtl/core/operator_token_lexer_top.sv
// ----------------------------------------------------------------------------
// operator_token_lexer_top
// Maximal-munch lexer for C-style operator tokens, one character an item.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with char_code and end_of_text. An item
// is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with token_code, is_error,
// error_position and last; last marks the final result of an input item.
// Each item gives zero, one or two results. The front end takes one item
// per cycle while the four-entry queue has room; the back end sends one
// result per cycle while out_stall is low, so an item with two results is
// sent as two results in turn; results pass the queue and output register.
// An end_of_text item flushes a pending one-character operator and returns
// the lexer state to reset; after an error only the position advances.
// Reset (rst, synchronous) clears the lexer state, the queue and the output
// register. While out_stall is high the output holds; the queue fills and
// in_stall rises once all four entries are taken.
// ----------------------------------------------------------------------------
module operator_token_lexer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  char_code,
  input  logic                        end_of_text,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  token_code,
  output logic                        is_error,
  output logic [otl_pkg::ErrPosW-1:0] error_position,
  output logic                        last
);

  logic            accept;
  logic            push;
  otl_pkg::entry_t push_entry;
  logic            pop;
  otl_pkg::entry_t pop_entry;
  logic            q_full;
  logic            q_empty;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  otl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .push        (push),
    .entry       (push_entry)
  );

  otl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty)
  );

  otl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_entry        (pop_entry),
    .q_empty        (q_empty),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .token_code     (token_code),
    .is_error       (is_error),
    .error_position (error_position),
    .last           (last)
  );

endmodule

FILE: rtl/core/otl_checker.sv
// ----------------------------------------------------------------------------
// otl_checker
// Port-level checks of the operator token lexer, bound to the top level.
// ----------------------------------------------------------------------------
module otl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [4:0]                  token_code,
  input logic                        is_error,
  input logic [otl_pkg::ErrPosW-1:0] error_position,
  input logic                        last
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_code) && $stable(is_error)
      && $stable(error_position) && $stable(last))
    else $error("stalled result changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && is_error |-> token_code == otl_pkg::TokNone && last)
    else $error("error result carries a token or is not last");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_error |-> error_position == '0 && token_code <= otl_pkg::TokMod)
    else $error("token result malformed");

endmodule

bind operator_token_lexer_top otl_checker u_otl_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .token_code     (token_code),
  .is_error       (is_error),
  .error_position (error_position),
  .last           (last)
);
